// File: rtl/apc_pkg.sv
// Shared types and constants for the all-pairs proximity checker.
`default_nettype none
package apc_pkg;

  localparam int MAX_AGENTS = 8;
  localparam int COORD_BITS = 24;

  localparam int AGENT_W    = 3;
  localparam int AIDX_W     = $clog2(MAX_AGENTS);
  localparam int ACT_W      = 4;
  localparam int TOL_W      = 53;
  localparam int DLIM_W     = 27;
  localparam int SQ_W       = 2 * DLIM_W;
  localparam int SUM_W      = SQ_W + 2;
  localparam int POINT_W    = 3 * COORD_BITS;
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 64;

  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(40000);
  localparam logic [ACT_W-1:0] ACT_RESET = ACT_W'(8);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef coord_t [2:0] point_t;

  typedef enum logic [1:0] {
    MODE_ORIGIN = 2'd0,
    MODE_SAMPLE = 2'd1,
    MODE_TICK   = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic {
    REG_TOL    = 1'b0,
    REG_ACTIVE = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SAMPLE,
    ST_WALK,
    ST_DRAIN,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [AIDX_W-1:0] first;
    logic [AIDX_W-1:0] second;
    logic              last;
  } pair_meta_t;

  typedef struct packed {
    logic       valid;
    logic       hit;
    pair_meta_t meta;
    point_t     mid;
  } pair_res_t;

endpackage
`default_nettype wire

// File: rtl/apc_ram.sv
// Generic synchronous RAM with one write port and registered read ports.
`default_nettype none
module apc_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 8,
  parameter int NUM_RD = 1,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire                                clk,
  input  wire                                we,
  input  wire  [ADDR_W-1:0]                  waddr,
  input  wire  [WIDTH-1:0]                   wdata,
  input  wire  [NUM_RD-1:0][ADDR_W-1:0]      raddr,
  output logic [NUM_RD-1:0][WIDTH-1:0]       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [NUM_RD-1:0][WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_RD; k++) begin
      rdata_r[k] <= mem[raddr[k]];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// File: rtl/apc_cfg.sv
// APB register file holding the squared tolerance and the active agent count.
`default_nettype none
module apc_cfg
  import apc_pkg::*;
(
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     psel,
  input  wire                     penable,
  input  wire                     pwrite,
  input  wire  [APB_ADDR_W-1:0]   paddr,
  input  wire  [APB_DATA_W-1:0]   pwdata,
  output logic [APB_DATA_W-1:0]   prdata,
  output logic                    pready,
  output logic [TOL_W-1:0]        tol_sq,
  output logic [ACT_W-1:0]        active
);

  logic [TOL_W-1:0] tol_r, tol_nxt;
  logic [ACT_W-1:0] act_r, act_nxt;
  logic             wr_en;
  reg_idx_t         idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[3]);

  always_comb begin
    tol_nxt = tol_r;
    act_nxt = act_r;
    if (wr_en) begin
      unique case (idx)
        REG_TOL:    tol_nxt = pwdata[TOL_W-1:0];
        REG_ACTIVE: act_nxt = pwdata[ACT_W-1:0];
        default:    tol_nxt = tol_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_TOL:    prdata = APB_DATA_W'(tol_r);
      REG_ACTIVE: prdata = APB_DATA_W'(act_r);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
      act_r <= ACT_RESET;
    end else begin
      tol_r <= tol_nxt;
      act_r <= act_nxt;
    end
  end

  assign tol_sq = tol_r;
  assign active = act_r;

endmodule
`default_nettype wire

// File: rtl/apc_pair.sv
// Three-stage pipeline that tests one pair for proximity and forms its midpoint.
`default_nettype none
module apc_pair
  import apc_pkg::*;
(
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_vld,
  input  pair_meta_t        in_meta,
  input  point_t            pos_a,
  input  point_t            pos_b,
  input  wire  [TOL_W-1:0]  tol_sq,
  output pair_res_t         res
);

  localparam int DIFF_W = COORD_BITS + 1;

  logic                         s1_vld_r, s2_vld_r, s3_vld_r;
  pair_meta_t                   s1_meta_r, s2_meta_r, s3_meta_r;
  point_t                       s1_mid_r, s2_mid_r, s3_mid_r;
  logic                         s1_far_r, s2_far_r;
  logic                         s3_hit_r;
  logic [2:0][DLIM_W-1:0]       s1_abs_r;
  logic [2:0][SQ_W-1:0]         s2_sq_r;

  logic                         far_nxt;
  logic [2:0][DLIM_W-1:0]       abs_nxt;
  point_t                       mid_nxt;
  logic [2:0][SQ_W-1:0]         sq_nxt;
  logic [SUM_W-1:0]             sum;

  always_comb begin
    logic signed [DIFF_W-1:0] d;
    logic signed [DIFF_W-1:0] s;
    logic        [DIFF_W-1:0] ad;
    far_nxt = 1'b0;
    for (int k = 0; k < 3; k++) begin
      d = DIFF_W'(pos_a[k]) - DIFF_W'(pos_b[k]);
      s = DIFF_W'(pos_a[k]) + DIFF_W'(pos_b[k]);
      ad = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
      if ((ad >> DLIM_W) != '0) begin
        far_nxt = 1'b1;
      end
      abs_nxt[k] = DLIM_W'(ad);
      mid_nxt[k] = COORD_BITS'(s >>> 1);
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sq_nxt[k] = SQ_W'(s1_abs_r[k]) * SQ_W'(s1_abs_r[k]);
    end
  end

  assign sum = SUM_W'(s2_sq_r[0]) + SUM_W'(s2_sq_r[1]) + SUM_W'(s2_sq_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_meta_r <= in_meta;
    s1_mid_r  <= mid_nxt;
    s1_far_r  <= far_nxt;
    s1_abs_r  <= abs_nxt;
    s2_meta_r <= s1_meta_r;
    s2_mid_r  <= s1_mid_r;
    s2_far_r  <= s1_far_r;
    s2_sq_r   <= sq_nxt;
    s3_meta_r <= s2_meta_r;
    s3_mid_r  <= s2_mid_r;
    s3_hit_r  <= ~s2_far_r & (sum <= SUM_W'(tol_sq));
  end

  assign res.valid = s3_vld_r;
  assign res.hit   = s3_hit_r;
  assign res.meta  = s3_meta_r;
  assign res.mid   = s3_mid_r;

endmodule
`default_nettype wire

// File: rtl/all_pairs_proximity_check.sv
// Top level: origin and position tables, sample update and the pairwise tick walk.
//
//   channel   handshake            payload
//   input     start / busy         in_mode, in_agent_index, in_coord_x/y/z
//   result    out_valid (strobe)   out_hit, out_first_agent, out_second_agent,
//                                  out_mid_x/y/z, out_last
//   config    APB psel/penable     paddr, pwdata, prdata (64-bit data bus, registers at 0 and 8)
//
// An origin load is written when it is accepted; a position sample first reads the origin
// memory, then its saturating add is written to the position memory in the sample state.
// A tick issues one pair per cycle from the dual-read position memory, then drains
// the distance pipeline and sends the final result from the flush state, to which it
// goes straight when fewer than two agents are active.
// Reset is synchronous and clears both tables through per-entry valid bits.
// Results appear for one cycle each and cannot be held off.
`default_nettype none
module all_pairs_proximity_check
  import apc_pkg::*;
(
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  output logic                         busy,
  input  wire  [1:0]                   in_mode,
  input  wire  [AGENT_W-1:0]           in_agent_index,
  input  wire  signed [COORD_BITS-1:0] in_coord_x,
  input  wire  signed [COORD_BITS-1:0] in_coord_y,
  input  wire  signed [COORD_BITS-1:0] in_coord_z,
  output logic                         out_valid,
  output logic                         out_hit,
  output logic [AGENT_W-1:0]           out_first_agent,
  output logic [AGENT_W-1:0]           out_second_agent,
  output logic signed [COORD_BITS-1:0] out_mid_x,
  output logic signed [COORD_BITS-1:0] out_mid_y,
  output logic signed [COORD_BITS-1:0] out_mid_z,
  output logic                         out_last,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [APB_ADDR_W-1:0]        paddr,
  input  wire  [APB_DATA_W-1:0]        pwdata,
  output logic [APB_DATA_W-1:0]        prdata,
  output logic                         pready
);

  state_t                 state_r, state_nxt;
  logic [TOL_W-1:0]       tol_sq;
  logic [ACT_W-1:0]       active;
  logic [ACT_W-1:0]       n_eff;
  logic [ACT_W-1:0]       n_r;

  logic                   accept;
  mode_t                  mode;
  logic                   in_range;
  logic [AIDX_W-1:0]      in_idx;
  point_t                 in_pt;

  logic [MAX_AGENTS-1:0]  org_vld_r, pos_vld_r;
  logic                   org_rv_r;
  logic [AIDX_W-1:0]      smp_idx_r;
  point_t                 smp_pt_r;
  logic                   org_we;
  logic [0:0][AIDX_W-1:0] org_raddr;
  logic [0:0][POINT_W-1:0] org_rdata;
  point_t                 org_pt;
  point_t                 sat_pt;
  logic                   pos_we;
  logic [1:0][AIDX_W-1:0] pos_raddr;
  logic [1:0][POINT_W-1:0] pos_rdata;
  logic                   pva_r, pvb_r;
  point_t                 pos_a, pos_b;

  logic [AIDX_W-1:0]      i_r, j_r;
  logic                   last_pair;
  logic                   issue;
  logic                   flush;
  logic                   s0_vld_r;
  pair_meta_t             s0_meta_r;
  pair_res_t              res;

  logic                   pend_v_r;
  pair_meta_t             pend_meta_r;
  point_t                 pend_mid_r;

  logic                   emit;
  logic                   emit_hit;
  logic                   emit_last;
  pair_meta_t             emit_meta;
  point_t                 emit_mid;

  logic                   out_valid_r, out_hit_r, out_last_r;
  logic [AGENT_W-1:0]     out_first_r, out_second_r;
  point_t                 out_mid_r;

  apc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .tol_sq  (tol_sq),
    .active  (active)
  );

  assign accept   = start & ~busy;
  assign mode     = mode_t'(in_mode);
  assign in_range = (ACT_W'(in_agent_index) < ACT_W'(MAX_AGENTS));
  assign in_idx   = AIDX_W'(in_agent_index);
  assign in_pt    = {in_coord_z, in_coord_y, in_coord_x};
  assign n_eff    = (active > ACT_W'(MAX_AGENTS)) ? ACT_W'(MAX_AGENTS) : active;

  assign org_we       = accept & (mode == MODE_ORIGIN) & in_range;
  assign org_raddr[0] = in_idx;

  apc_ram #(
    .WIDTH  (POINT_W),
    .DEPTH  (MAX_AGENTS),
    .NUM_RD (1)
  ) u_org_ram (
    .clk   (clk),
    .we    (org_we),
    .waddr (in_idx),
    .wdata (in_pt),
    .raddr (org_raddr),
    .rdata (org_rdata)
  );

  assign org_pt = org_rv_r ? point_t'(org_rdata[0]) : '0;

  always_comb begin
    logic signed [COORD_BITS:0] s;
    for (int k = 0; k < 3; k++) begin
      s = (COORD_BITS+1)'(org_pt[k]) + (COORD_BITS+1)'(smp_pt_r[k]);
      if (s[COORD_BITS] != s[COORD_BITS-1]) begin
        sat_pt[k] = s[COORD_BITS] ? {1'b1, {(COORD_BITS-1){1'b0}}}
                                  : {1'b0, {(COORD_BITS-1){1'b1}}};
      end else begin
        sat_pt[k] = s[COORD_BITS-1:0];
      end
    end
  end

  assign pos_raddr[0] = i_r;
  assign pos_raddr[1] = j_r;

  apc_ram #(
    .WIDTH  (POINT_W),
    .DEPTH  (MAX_AGENTS),
    .NUM_RD (2)
  ) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .waddr (smp_idx_r),
    .wdata (sat_pt),
    .raddr (pos_raddr),
    .rdata (pos_rdata)
  );

  assign pos_a = pva_r ? point_t'(pos_rdata[0]) : '0;
  assign pos_b = pvb_r ? point_t'(pos_rdata[1]) : '0;

  assign last_pair = (ACT_W'(i_r) == n_r - ACT_W'(2));

  apc_pair u_pair (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (s0_vld_r),
    .in_meta (s0_meta_r),
    .pos_a   (pos_a),
    .pos_b   (pos_b),
    .tol_sq  (tol_sq),
    .res     (res)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (mode)
            MODE_SAMPLE: state_nxt = in_range ? ST_SAMPLE : ST_IDLE;
            MODE_TICK:   state_nxt = (n_eff >= ACT_W'(2)) ? ST_WALK : ST_FLUSH;
            default:     state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SAMPLE: state_nxt = ST_IDLE;
      ST_WALK:   state_nxt = last_pair ? ST_DRAIN : ST_WALK;
      ST_DRAIN:  state_nxt = (res.valid & res.meta.last) ? ST_FLUSH : ST_DRAIN;
      ST_FLUSH:  state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    busy   = 1'b1;
    pos_we = 1'b0;
    issue  = 1'b0;
    flush  = 1'b0;
    unique case (state_r)
      ST_IDLE:   busy   = 1'b0;
      ST_SAMPLE: pos_we = 1'b1;
      ST_WALK:   issue  = 1'b1;
      ST_DRAIN:  busy   = 1'b1;
      ST_FLUSH:  flush  = 1'b1;
      default:   busy   = 1'b1;
    endcase
  end

  always_comb begin
    emit      = 1'b0;
    emit_hit  = 1'b1;
    emit_last = 1'b0;
    emit_meta = pend_meta_r;
    emit_mid  = pend_mid_r;
    if (flush) begin
      emit      = 1'b1;
      emit_last = 1'b1;
      emit_hit  = pend_v_r;
      if (!pend_v_r) begin
        emit_meta = '0;
        emit_mid  = '0;
      end
    end else if (res.valid & res.hit & pend_v_r) begin
      emit = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      org_vld_r   <= '0;
      pos_vld_r   <= '0;
      s0_vld_r    <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      s0_vld_r    <= issue;
      out_valid_r <= emit;
      if (org_we) begin
        org_vld_r[in_idx] <= 1'b1;
      end
      if (pos_we) begin
        pos_vld_r[smp_idx_r] <= 1'b1;
      end
      if (accept & (mode == MODE_TICK)) begin
        pend_v_r <= 1'b0;
      end else if (res.valid & res.hit) begin
        pend_v_r <= 1'b1;
      end else if (flush) begin
        pend_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    org_rv_r <= in_range ? org_vld_r[in_idx] : 1'b0;
    pva_r    <= pos_vld_r[i_r];
    pvb_r    <= pos_vld_r[j_r];
    if (accept) begin
      smp_idx_r <= in_idx;
      smp_pt_r  <= in_pt;
    end
    if (accept & (mode == MODE_TICK)) begin
      n_r <= n_eff;
      i_r <= '0;
      j_r <= AIDX_W'(1);
    end else if (issue & !last_pair) begin
      if (ACT_W'(j_r) == n_r - ACT_W'(1)) begin
        i_r <= i_r + AIDX_W'(1);
        j_r <= i_r + AIDX_W'(2);
      end else begin
        j_r <= j_r + AIDX_W'(1);
      end
    end
    s0_meta_r.first  <= i_r;
    s0_meta_r.second <= j_r;
    s0_meta_r.last   <= last_pair;
    if (res.valid & res.hit) begin
      pend_meta_r <= res.meta;
      pend_mid_r  <= res.mid;
    end
    out_hit_r    <= emit_hit;
    out_last_r   <= emit_last;
    out_first_r  <= AGENT_W'(emit_meta.first);
    out_second_r <= AGENT_W'(emit_meta.second);
    out_mid_r    <= emit_mid;
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_last         = out_last_r;
  assign out_first_agent  = out_first_r;
  assign out_second_agent = out_second_r;
  assign out_mid_x        = out_mid_r[0];
  assign out_mid_y        = out_mid_r[1];
  assign out_mid_z        = out_mid_r[2];

endmodule
`default_nettype wire

// File: rtl/apc_checker.sv
// Port-level assertions for the proximity checker and their bind to the top level.
`default_nettype none
module apc_checker
  import apc_pkg::*;
(
  input wire                          clk,
  input wire                          rst_n,
  input wire                          start,
  input wire                          busy,
  input wire  [1:0]                   in_mode,
  input wire                          out_valid,
  input wire                          out_hit,
  input wire  [AGENT_W-1:0]           out_first_agent,
  input wire  [AGENT_W-1:0]           out_second_agent,
  input wire  signed [COORD_BITS-1:0] out_mid_x,
  input wire                          out_last
);

  // A result that names no pair closes its tick and carries zeros.
  a_miss_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_last && out_first_agent == '0 &&
    out_second_agent == '0 && out_mid_x == '0)
    else $error("miss result is not a clean final result");

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> out_first_agent < out_second_agent)
    else $error("pair indices out of order");

  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_mode == MODE_TICK |=> busy)
    else $error("tick transfer did not make the block busy");

  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !out_valid)
    else $error("result right after the final result of a tick");

endmodule

bind all_pairs_proximity_check apc_checker u_apc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_mode          (in_mode),
  .out_valid        (out_valid),
  .out_hit          (out_hit),
  .out_first_agent  (out_first_agent),
  .out_second_agent (out_second_agent),
  .out_mid_x        (out_mid_x),
  .out_last         (out_last)
);
`default_nettype wire

// File: verif/all_pairs_proximity_check_tb.sv
// Self-checking testbench for all_pairs_proximity_check with a built-in proximity predictor.
module all_pairs_proximity_check_tb;
  import apc_pkg::*;

  localparam longint CMAX = (longint'(1) << (COORD_BITS - 1)) - 1;
  localparam longint CMIN = -CMAX - 1;
  localparam longint DIFF_CAP = longint'(1) << DLIM_W;

  typedef struct packed {
    mode_t              mode;
    logic [AGENT_W-1:0] agent;
    point_t             xyz;
  } cmd_t;

  typedef struct packed {
    logic               hit;
    logic [AGENT_W-1:0] first;
    logic [AGENT_W-1:0] second;
    point_t             mid;
    logic               last;
  } report_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [1:0]            in_mode = MODE_NONE;
  logic [AGENT_W-1:0]    in_agent_index = '0;
  coord_t                in_coord_x = '0;
  coord_t                in_coord_y = '0;
  coord_t                in_coord_z = '0;
  logic                  out_valid;
  logic                  out_hit;
  logic [AGENT_W-1:0]    out_first_agent;
  logic [AGENT_W-1:0]    out_second_agent;
  coord_t                out_mid_x;
  coord_t                out_mid_y;
  coord_t                out_mid_z;
  logic                  out_last;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  cmd_t    pending_cmds[$];
  report_t expected_reports[$];
  point_t  origin_mm [MAX_AGENTS];
  point_t  world_pos [MAX_AGENTS];
  point_t  gen_origin [MAX_AGENTS];
  logic [TOL_W-1:0] tol_sq;
  logic [ACT_W-1:0] active_cnt;
  int      idle_pct = 0;
  int      bad_count = 0;

  all_pairs_proximity_check dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mode(in_mode), .in_agent_index(in_agent_index),
    .in_coord_x(in_coord_x), .in_coord_y(in_coord_y), .in_coord_z(in_coord_z),
    .out_valid(out_valid), .out_hit(out_hit),
    .out_first_agent(out_first_agent), .out_second_agent(out_second_agent),
    .out_mid_x(out_mid_x), .out_mid_y(out_mid_y), .out_mid_z(out_mid_z),
    .out_last(out_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint rnd_coord();
    coord_t c;
    c = coord_t'($urandom);
    return longint'(c);
  endfunction

  function automatic string fmt_report(report_t r);
    return $sformatf("hit=%0b pair=%0d,%0d mid=(%0d,%0d,%0d) last=%0b", r.hit, r.first,
                     r.second, r.mid[0], r.mid[1], r.mid[2], r.last);
  endfunction

  function automatic void apply_command(cmd_t c);
    longint s, a, b, d;
    longint unsigned dist_sq;
    int n, i, j, k, hits;
    bit near;
    report_t r;
    case (c.mode)
      MODE_ORIGIN: origin_mm[c.agent] = c.xyz;
      MODE_SAMPLE: begin
        for (k = 0; k < 3; k++) begin
          s = longint'($signed(origin_mm[c.agent][k])) + longint'($signed(c.xyz[k]));
          s = (s > CMAX) ? CMAX : ((s < CMIN) ? CMIN : s);
          world_pos[c.agent][k] = coord_t'(s);
        end
      end
      MODE_TICK: begin
        n = (active_cnt > MAX_AGENTS) ? MAX_AGENTS : int'(active_cnt);
        hits = 0;
        for (i = 0; i < n; i++) begin
          for (j = i + 1; j < n; j++) begin
            near = 1'b1;
            dist_sq = 0;
            for (k = 0; k < 3; k++) begin
              d = longint'($signed(world_pos[i][k])) - longint'($signed(world_pos[j][k]));
              if (d < 0) d = -d;
              if (d >= DIFF_CAP) near = 1'b0;
              else dist_sq += longint'(d * d);
            end
            if (near && dist_sq <= tol_sq) begin
              r.hit = 1'b1;
              r.first = AGENT_W'(i);
              r.second = AGENT_W'(j);
              for (k = 0; k < 3; k++) begin
                a = longint'($signed(world_pos[i][k]));
                b = longint'($signed(world_pos[j][k]));
                r.mid[k] = coord_t'((a + b) >>> 1);
              end
              r.last = 1'b0;
              expected_reports.insert(expected_reports.size(), r);
              hits++;
            end
          end
        end
        if (hits == 0) begin
          r = '0;
          r.last = 1'b1;
        end else begin
          r = expected_reports.pop_back();
          r.last = 1'b1;
        end
        expected_reports.insert(expected_reports.size(), r);
      end
      default: ;
    endcase
  endfunction

  function automatic void send(mode_t m, int a, longint x, longint y, longint z);
    cmd_t c;
    c.mode = m;
    c.agent = AGENT_W'(a);
    c.xyz[0] = coord_t'(x);
    c.xyz[1] = coord_t'(y);
    c.xyz[2] = coord_t'(z);
    if (m == MODE_ORIGIN) gen_origin[c.agent] = c.xyz;
    pending_cmds.insert(pending_cmds.size(), c);
  endfunction

  always @(posedge clk) begin
    cmd_t nxt;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (pending_cmds.size() != 0 && $urandom_range(99) >= idle_pct) begin
        nxt = pending_cmds[0];
        pending_cmds.delete(0);
        start <= 1'b1;
        in_mode <= nxt.mode;
        in_agent_index <= nxt.agent;
        in_coord_x <= nxt.xyz[0];
        in_coord_y <= nxt.xyz[1];
        in_coord_z <= nxt.xyz[2];
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    report_t seen, want;
    cmd_t taken;
    if (rst_n) begin
      if (out_valid) begin
        seen.hit = out_hit;
        seen.first = out_first_agent;
        seen.second = out_second_agent;
        seen.mid[0] = out_mid_x;
        seen.mid[1] = out_mid_y;
        seen.mid[2] = out_mid_z;
        seen.last = out_last;
        if (expected_reports.size() == 0) begin
          bad_count++;
          if (bad_count <= 10) $display("unexpected result: %s", fmt_report(seen));
        end else begin
          want = expected_reports[0];
          expected_reports.delete(0);
          if (seen !== want) begin
            bad_count++;
            if (bad_count <= 10)
              $display("mismatch: expected %s, got %s", fmt_report(want), fmt_report(seen));
          end
        end
      end
      if (start && !busy) begin
        taken.mode = mode_t'(in_mode);
        taken.agent = in_agent_index;
        taken.xyz[0] = in_coord_x;
        taken.xyz[1] = in_coord_y;
        taken.xyz[2] = in_coord_z;
        apply_command(taken);
      end
    end
  end

  task automatic wait_quiet();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || start || busy || expected_reports.size() != 0);
    repeat (40) @(negedge clk);
  endtask

  task automatic cfg_write(reg_idx_t r, logic [APB_DATA_W-1:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 3'b000};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (r)
      REG_TOL: tol_sq = v[TOL_W-1:0];
      REG_ACTIVE: active_cnt = v[ACT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic random_phase(int count, int spread);
    int made, members, m, a, k, s, off;
    longint center[3];
    longint pt[3];
    mode_t md;
    made = 0;
    while (made < count) begin
      if ($urandom_range(9) < 7) begin
        for (k = 0; k < 3; k++) begin
          case ($urandom_range(3))
            0: center[k] = CMAX - $urandom_range(300);
            1: center[k] = CMIN + $urandom_range(300);
            default: center[k] = rnd_coord();
          endcase
        end
        s = $urandom_range(spread);
        members = $urandom_range(2, 6);
        for (m = 0; m < members; m++) begin
          a = $urandom_range(MAX_AGENTS - 1);
          if ($urandom_range(3) == 0) begin
            if ($urandom_range(1) == 0)
              send(MODE_ORIGIN, a, rnd_coord(), rnd_coord(), rnd_coord());
            else
              send(MODE_ORIGIN, a, int'($urandom_range(2000)) - 1000,
                   int'($urandom_range(2000)) - 1000, int'($urandom_range(2000)) - 1000);
            made++;
          end
          for (k = 0; k < 3; k++) begin
            off = int'($urandom_range(2 * s)) - s;
            pt[k] = center[k] + off - longint'($signed(gen_origin[a][k]));
          end
          send(MODE_SAMPLE, a, pt[0], pt[1], pt[2]);
          made++;
        end
        send(MODE_TICK, $urandom_range(MAX_AGENTS - 1), rnd_coord(), rnd_coord(), rnd_coord());
        made++;
      end else begin
        md = mode_t'($urandom_range(3));
        send(md, $urandom_range(MAX_AGENTS - 1), rnd_coord(), rnd_coord(), rnd_coord());
        if (md != MODE_NONE) made++;
      end
    end
    send(MODE_TICK, 0, 0, 0, 0);
    wait_quiet();
  endtask

  initial begin
    for (int i = 0; i < MAX_AGENTS; i++) begin
      origin_mm[i] = '0;
      world_pos[i] = '0;
      gen_origin[i] = '0;
    end
    tol_sq = TOL_RESET;
    active_cnt = ACT_RESET;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    idle_pct = 0;
    send(MODE_TICK, 0, 0, 0, 0);
    send(MODE_ORIGIN, 0, CMAX, CMIN, 0);
    send(MODE_SAMPLE, 0, CMAX, CMIN, 1);
    send(MODE_ORIGIN, 1, CMIN, CMAX, -1);
    send(MODE_SAMPLE, 1, CMIN, CMAX, 0);
    send(MODE_SAMPLE, 2, CMAX, CMIN, 0);
    send(MODE_SAMPLE, 3, 1, -1, 3);
    send(MODE_SAMPLE, 4, 2, -2, 3);
    send(MODE_SAMPLE, 6, 0, 0, -201);
    send(MODE_SAMPLE, 7, 200, 0, 0);
    send(MODE_NONE, 5, CMAX, CMAX, CMAX);
    send(MODE_TICK, 7, CMIN, CMIN, CMIN);
    wait_quiet();
    cfg_write(REG_ACTIVE, 1);
    send(MODE_TICK, 0, 0, 0, 0);
    wait_quiet();
    cfg_write(REG_ACTIVE, 0);
    send(MODE_TICK, 0, 0, 0, 0);
    wait_quiet();
    cfg_write(REG_ACTIVE, 8);
    random_phase(35, 150);

    idle_pct = 83;
    cfg_write(REG_TOL, 64'd4503599627370496);
    cfg_write(REG_ACTIVE, 15);
    random_phase(40, 5000);

    idle_pct = 19;
    cfg_write(REG_TOL, 0);
    cfg_write(REG_ACTIVE, 2);
    random_phase(40, 1);

    idle_pct = 0;
    cfg_write(REG_TOL, 250000);
    cfg_write(REG_ACTIVE, 6);
    random_phase(35, 400);

    if (bad_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
